// ----- rtl/text_integer_field_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text integer field parser
// Same-cycle and next-cycle implication checks, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_INTEGER_FIELD_PARSER_DEFINES_SVH
`define TEXT_INTEGER_FIELD_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define TIFP_ASSERT_SAME(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("tifp same-cycle check failed");
`define TIFP_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("tifp next-cycle check failed");
`else
`define TIFP_ASSERT_SAME(lbl, clk, rst_n, ant, cons)
`define TIFP_ASSERT_NEXT(lbl, clk, rst_n, ant, cons)
`endif
`endif

// ----- rtl/tifp_pkg.sv -----
// ----------------------------------------------------------------------------
// tifp_pkg
// Types, character codes and digit decoding for the text integer field parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tifp_pkg;

  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 14;
  localparam int FUNC_W      = 3;
  localparam int IN_TDATA_W  = 24;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [FUNC_W-1:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_OCT  = 3'd2,
    KIND_HEX  = 3'd3,
    KIND_AUTO = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HELD   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_HOLD,
    RES_GO,
    RES_TAKE_END,
    RES_LEAVE_END
  } step_res_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] max_digits;
    logic [FUNC_W-1:0]  func;
    logic               start_req;
    logic [CHAR_W-1:0]  ch;
  } in_item_t;

  typedef struct packed {
    logic done_res;
    logic consumed;
  } step_flags_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } digit_t;

  // Unknown field kinds fall back to signed decimal.
  function automatic kind_t kind_of_func(logic [FUNC_W-1:0] f);
    kind_t k;
    if (f inside {KIND_UDEC, KIND_OCT, KIND_HEX, KIND_AUTO}) begin
      k = kind_t'(f);
    end else begin
      k = KIND_SDEC;
    end
    return k;
  endfunction

  // Letters a-f and A-F both carry a low nibble of 1..6, so the value is nibble + 9.
  function automatic digit_t digit_val(kind_t k, logic [CHAR_W-1:0] c);
    digit_t d;
    d.valid = 1'b0;
    d.val   = c[3:0];
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d.valid = (k != KIND_OCT) || (c <= CH_SEVEN);
    end else if ((k == KIND_HEX) &&
                 (c inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]})) begin
      d.valid = 1'b1;
      d.val   = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tifp_core.sv -----
// ----------------------------------------------------------------------------
// tifp_core
// Field state registers and the combinational parse step for one character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_integer_field_parser_defines.svh"

module tifp_core
  import tifp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire in_item_t              item,
  output logic      [VALUE_BITS-1:0] res_value,
  output step_flags_t                res_flags
);

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [DIGIT_W-1:0]    used_r, used_nxt;
  logic [DIGIT_W-1:0]    lim_r, lim_nxt;
  kind_t                 kind_r, kind_nxt;
  logic                  neg_r, neg_nxt;
  logic [CHAR_W-1:0]     held_r, held_nxt;
  phase_t                phase_r, phase_nxt;

  logic [VALUE_BITS-1:0] pre_acc, scaled;
  logic [DIGIT_W-1:0]    pre_used, pre_lim, used_inc;
  kind_t                 pre_kind, start_kind, held_kind;
  digit_t                dig, held_dig;
  logic                  take;
  step_res_t             res;

  always_comb begin
    start_kind = kind_of_func(item.func);
    // An auto field without an x prefix is octal after a leading zero.
    if (kind_r == KIND_AUTO) begin
      held_kind = (held_r == CH_ZERO) ? KIND_OCT : KIND_SDEC;
    end else begin
      held_kind = kind_r;
    end
    held_dig = digit_val(held_kind, held_r);

    acc_nxt   = acc_r;
    used_nxt  = used_r;
    lim_nxt   = lim_r;
    kind_nxt  = kind_r;
    neg_nxt   = neg_r;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    pre_acc   = acc_r;
    pre_used  = used_r;
    pre_lim   = lim_r;
    pre_kind  = kind_r;
    take      = 1'b0;
    res       = RES_NONE;

    if (item.start_req) begin
      acc_nxt   = '0;
      used_nxt  = '0;
      lim_nxt   = item.max_digits;
      kind_nxt  = start_kind;
      neg_nxt   = 1'b0;
      pre_acc   = '0;
      pre_used  = '0;
      pre_lim   = item.max_digits;
      pre_kind  = start_kind;
      phase_nxt = PH_DIGITS;
      if ((start_kind == KIND_HEX) || (start_kind == KIND_AUTO)) begin
        held_nxt  = item.ch;
        phase_nxt = PH_HELD;
        res       = RES_HOLD;
      end else if (item.ch == CH_MINUS) begin
        neg_nxt = (start_kind == KIND_SDEC);
        if (item.max_digits == '0) begin
          phase_nxt = PH_IDLE;
          res       = RES_TAKE_END;
        end else begin
          res = RES_GO;
        end
      end else begin
        take = 1'b1;
      end
    end else if (phase_r == PH_DIGITS) begin
      take = 1'b1;
    end else if (phase_r == PH_HELD) begin
      if ((item.ch == CH_LO_X) || (item.ch == CH_UP_X)) begin
        kind_nxt = KIND_HEX;
        if (lim_r == '0) begin
          phase_nxt = PH_IDLE;
          res       = RES_TAKE_END;
        end else begin
          phase_nxt = PH_DIGITS;
          res       = RES_GO;
        end
      end else begin
        // The held character is replayed first; the new one follows it.
        kind_nxt  = held_kind;
        pre_kind  = held_kind;
        phase_nxt = PH_DIGITS;
        if ((held_kind == KIND_SDEC) && (held_r == CH_MINUS)) begin
          neg_nxt = 1'b1;
          if (lim_r == '0) begin
            phase_nxt = PH_IDLE;
            res       = RES_LEAVE_END;
          end else begin
            take = 1'b1;
          end
        end else if ((lim_r == '0) || !held_dig.valid) begin
          phase_nxt = PH_IDLE;
          res       = RES_LEAVE_END;
        end else begin
          acc_nxt  = VALUE_BITS'(held_dig.val);
          used_nxt = DIGIT_W'(1);
          pre_acc  = VALUE_BITS'(held_dig.val);
          pre_used = DIGIT_W'(1);
          if (lim_r == DIGIT_W'(1)) begin
            phase_nxt = PH_IDLE;
            res       = RES_LEAVE_END;
          end else begin
            take = 1'b1;
          end
        end
      end
    end

    dig      = digit_val(pre_kind, item.ch);
    used_inc = pre_used + DIGIT_W'(1);
    case (pre_kind)
      KIND_HEX: scaled = pre_acc << 4;
      KIND_OCT: scaled = pre_acc << 3;
      default:  scaled = (pre_acc << 3) + (pre_acc << 1);
    endcase

    if (take) begin
      if ((pre_used >= pre_lim) || !dig.valid) begin
        phase_nxt = PH_IDLE;
        res       = RES_LEAVE_END;
      end else begin
        acc_nxt  = scaled + VALUE_BITS'(dig.val);
        used_nxt = used_inc;
        if (used_inc == pre_lim) begin
          phase_nxt = PH_IDLE;
          res       = RES_TAKE_END;
        end else begin
          phase_nxt = PH_DIGITS;
          res       = RES_GO;
        end
      end
    end

    res_value = neg_nxt ? (~acc_nxt + VALUE_BITS'(1)) : acc_nxt;
    res_flags.consumed = (res == RES_HOLD) || (res == RES_GO) || (res == RES_TAKE_END);
    res_flags.done_res = (res == RES_TAKE_END) || (res == RES_LEAVE_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      used_r  <= '0;
      lim_r   <= '0;
      kind_r  <= KIND_SDEC;
      neg_r   <= 1'b0;
      held_r  <= '0;
      phase_r <= PH_IDLE;
    end else if (step_en) begin
      acc_r   <= acc_nxt;
      used_r  <= used_nxt;
      lim_r   <= lim_nxt;
      kind_r  <= kind_nxt;
      neg_r   <= neg_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
    end
  end

  `TIFP_ASSERT_NEXT(a_done_closes_field, clk, rst_n, step_en && res_flags.done_res, phase_r == PH_IDLE)
  `TIFP_ASSERT_SAME(a_consume_needs_field, clk, rst_n, step_en && res_flags.consumed, item.start_req || (phase_r != PH_IDLE))
  `TIFP_ASSERT_SAME(a_used_within_limit, clk, rst_n, 1'b1, used_r <= lim_r)
  `TIFP_ASSERT_SAME(a_held_kind, clk, rst_n, phase_r == PH_HELD, (kind_r == KIND_HEX) || (kind_r == KIND_AUTO))

endmodule

`default_nettype wire

// ----- rtl/text_integer_field_parser.sv -----
// ----------------------------------------------------------------------------
// text_integer_field_parser
// Streaming ASCII-to-integer field parser, one character per beat.
// ----------------------------------------------------------------------------
// Every input beat carries one character and yields exactly one result beat:
// the running field value (negated for a negative signed decimal field,
// wrapping modulo 2^VALUE_BITS), tlast when the field ends on that character,
// and tuser set when the character belongs to the field. A beat with the
// start flag opens a field of the given kind and digit limit. The block
// sustains one beat per clock while the output is not stalled. An accepted
// item sits in the input register while the combinational parse step works
// on it, and the result register loads from the step once the output can
// advance. The constant-multiply accumulate of the parse step bounds the
// clock. A stalled result holds the input register and drops in_tready only
// while both registers are full.
`timescale 1ns / 1ps
`default_nettype none
`include "text_integer_field_parser_defines.svh"

module text_integer_field_parser
  import tifp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [IN_TDATA_W-1:0]                 in_tdata,  // ch, max_digits
  input  wire logic [FUNC_W:0]                       in_tuser,  // start_req, func
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic      [((VALUE_BITS + 7) / 8) * 8-1:0] out_tdata, // value
  output logic                                       out_tlast,
  output logic                                       out_tuser  // consumed
);

  localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

  logic                  in_valid_r;
  in_item_t              in_item_r;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  step_flags_t           out_flags_r;
  logic                  advance, step_en;
  logic [VALUE_BITS-1:0] res_value;
  step_flags_t           res_flags;
  logic [OUT_TDATA_W-1:0] out_data;

  assign advance   = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.ch         <= in_tdata[CHAR_W-1:0];
      in_item_r.max_digits <= in_tdata[CHAR_W+DIGIT_W-1:CHAR_W];
      in_item_r.start_req  <= in_tuser[0];
      in_item_r.func       <= in_tuser[FUNC_W:1];
    end
  end

  tifp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_item_r),
    .res_value (res_value),
    .res_flags (res_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_value_r <= res_value;
      out_flags_r <= res_flags;
    end
  end

  always_comb begin
    out_data                   = '0;
    out_data[VALUE_BITS-1:0]   = out_value_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data;
  assign out_tlast  = out_flags_r.done_res;
  assign out_tuser  = out_flags_r.consumed;

  `TIFP_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, in_tvalid && in_tready, in_valid_r)
  `TIFP_ASSERT_NEXT(a_step_gives_result, clk, rst_n, step_en, out_valid_r)
  `TIFP_ASSERT_NEXT(a_stall_keeps_input, clk, rst_n, in_valid_r && out_valid_r && !out_tready, in_valid_r)

endmodule

`default_nettype wire
